>>> rtl/core/dws_pkg.sv
// Shared types and constants for the dictionary word substituter.
// Word layouts, command codes, job kinds and sequencer states. No dependencies.
`default_nettype none
package dws_pkg;

    localparam logic [7:0] SEP_SPACE   = 8'd32;
    localparam logic [7:0] SEP_NEWLINE = 8'd10;

    typedef enum logic [1:0] {
        CMD_PAT  = 2'd0,
        CMD_CODE = 2'd1,
        CMD_LEN  = 2'd2,
        CMD_TEXT = 2'd3
    } t_cmd;

    typedef struct packed {
        logic [1:0] command;
        logic [7:0] entry;
        logic [3:0] position;
        logic [7:0] char_in;
        logic [4:0] pattern_length;
        logic [4:0] code_length;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last;
        logic       overflow;
    } t_out_item;

    typedef enum logic [2:0] {
        K_DROP,
        K_PAT,
        K_CODE,
        K_LEN,
        K_TEXT,
        K_SEP
    } t_kind;

    typedef struct packed {
        t_kind    kind;
        t_in_item item;
    } t_job;

    typedef struct packed {
        logic valid;
        logic pop;
    } t_job_hs;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LEN_ISSUE,
        S_LEN_CHK,
        S_CMP_ISSUE,
        S_CMP_CHK,
        S_EMIT_ISSUE,
        S_EMIT_PUT,
        S_SEP
    } t_state;

endpackage
`default_nettype wire

>>> rtl/core/dws_ram.sv
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module dws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                     i_wdata,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

>>> rtl/core/dws_front.sv
// Front end: takes input words, classifies them and queues them (two deep).
// Uses dws_pkg.
`default_nettype none
module dws_front #(
    parameter int DICT_ENTRIES = 256,
    parameter int PATTERN_MAX  = 16,
    parameter int CODE_MAX     = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    input  wire dws_pkg::t_in_item i_item,
    output logic                   o_in_stall,
    output dws_pkg::t_job          o_job,
    output dws_pkg::t_job_hs       o_hs_valid,
    input  wire dws_pkg::t_job_hs  i_hs_pop
);
    import dws_pkg::*;

    t_job       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       n_wp, n_rp;
    logic [1:0] n_cnt;
    logic       w_push, w_pop;
    t_job       w_job;

    always_comb begin
        w_job      = '{kind: K_DROP, item: i_item};
        unique case (t_cmd'(i_item.command))
            CMD_PAT: begin
                if (11'(i_item.entry) < 11'(DICT_ENTRIES) &&
                    5'(i_item.position) < 5'(PATTERN_MAX)) begin
                    w_job.kind = K_PAT;
                end
            end
            CMD_CODE: begin
                if (11'(i_item.entry) < 11'(DICT_ENTRIES) &&
                    5'(i_item.position) < 5'(CODE_MAX)) begin
                    w_job.kind = K_CODE;
                end
            end
            CMD_LEN: begin
                if (11'(i_item.entry) < 11'(DICT_ENTRIES)) begin
                    w_job.kind = K_LEN;
                end
                if (i_item.pattern_length > 5'(PATTERN_MAX)) begin
                    w_job.item.pattern_length = 5'(PATTERN_MAX);
                end
                if (i_item.code_length > 5'(CODE_MAX)) begin
                    w_job.item.code_length = 5'(CODE_MAX);
                end
            end
            CMD_TEXT: begin
                if (i_item.char_in == SEP_SPACE || i_item.char_in == SEP_NEWLINE) begin
                    w_job.kind = K_SEP;
                end else begin
                    w_job.kind = K_TEXT;
                end
            end
            default: w_job.kind = K_DROP;
        endcase
    end

    assign o_in_stall = (r_cnt == 2'd2);
    assign w_push     = i_in_valid && !o_in_stall;
    assign w_pop      = i_hs_pop.pop && (r_cnt != 2'd0);

    always_comb begin
        n_wp  = w_push ? !r_wp : r_wp;
        n_rp  = w_pop ? !r_rp : r_rp;
        n_cnt = r_cnt + 2'(w_push) - 2'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_job;
        end
    end

    assign o_job            = r_q[r_rp];
    assign o_hs_valid.valid = (r_cnt != 2'd0);
    assign o_hs_valid.pop   = 1'b0;
endmodule
`default_nettype wire

>>> rtl/core/dws_back.sv
// Back end: dictionary stores, word buffer, pattern search and output sequencer.
// Uses dws_pkg and dws_ram.
`default_nettype none
module dws_back #(
    parameter int DICT_ENTRIES = 256,
    parameter int WORD_MAX     = 32,
    parameter int PATTERN_MAX  = 16,
    parameter int CODE_MAX     = 16,
    parameter int CW           = $clog2(DICT_ENTRIES + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [CW-1:0]      i_limit,
    input  wire dws_pkg::t_job      i_job,
    input  wire dws_pkg::t_job_hs   i_hs_valid,
    output dws_pkg::t_job_hs        o_hs_pop,
    output logic                    o_out_valid,
    output dws_pkg::t_out_item      o_item,
    input  wire logic               i_out_stall
);
    import dws_pkg::*;

    localparam int EW  = DICT_ENTRIES > 1 ? $clog2(DICT_ENTRIES) : 1;
    localparam int IW  = $clog2(WORD_MAX);
    localparam int LW  = $clog2(WORD_MAX + 1);
    localparam int TW  = $clog2(WORD_MAX + CODE_MAX + 1);
    localparam int SW  = 8;
    localparam int PAD = DICT_ENTRIES * PATTERN_MAX;
    localparam int CAD = DICT_ENTRIES * CODE_MAX;
    localparam int PAW = PAD > 1 ? $clog2(PAD) : 1;
    localparam int CAW = CAD > 1 ? $clog2(CAD) : 1;

    t_state          r_state, n_state;
    logic [7:0]      r_word [WORD_MAX];
    logic [LW-1:0]   r_wlen, n_wlen;
    logic            r_wovf, n_wovf;
    logic [CW-1:0]   r_e, n_e;
    logic [4:0]      r_plen, n_plen, r_clen, n_clen, r_j, n_j;
    logic [LW-1:0]   r_off, n_off, r_start, n_start;
    logic [TW-1:0]   r_k, n_k, r_total, n_total;
    logic [7:0]      r_sep, n_sep;
    logic            r_ovalid, n_ovalid;
    t_out_item       r_oitem, n_oitem;

    logic            w_pop, w_slot;
    logic [SW-1:0]   w_sk, w_widx_s, w_coff, w_htotal;
    logic [IW-1:0]   w_widx;
    logic            w_in_code, w_last_entry;
    logic [7:0]      w_wbyte;
    logic            w_pat_we, w_code_we, w_len_we;
    logic [PAW-1:0]  w_pat_waddr, w_pat_raddr;
    logic [CAW-1:0]  w_code_waddr, w_code_raddr;
    logic [EW-1:0]   w_len_waddr, w_len_raddr;
    logic [7:0]      w_pat_rdata, w_code_rdata;
    logic [9:0]      w_len_rdata;

    dws_ram #(.WIDTH(8), .DEPTH(PAD)) u_pat (
        .i_clk(i_clk), .i_we(w_pat_we), .i_waddr(w_pat_waddr),
        .i_wdata(i_job.item.char_in), .i_raddr(w_pat_raddr), .o_rdata(w_pat_rdata)
    );
    dws_ram #(.WIDTH(8), .DEPTH(CAD)) u_code (
        .i_clk(i_clk), .i_we(w_code_we), .i_waddr(w_code_waddr),
        .i_wdata(i_job.item.char_in), .i_raddr(w_code_raddr), .o_rdata(w_code_rdata)
    );
    dws_ram #(.WIDTH(10), .DEPTH(DICT_ENTRIES)) u_len (
        .i_clk(i_clk), .i_we(w_len_we), .i_waddr(w_len_waddr),
        .i_wdata({i_job.item.pattern_length, i_job.item.code_length}),
        .i_raddr(w_len_raddr), .o_rdata(w_len_rdata)
    );

    assign w_pop        = (r_state == S_IDLE) && i_hs_valid.valid;
    assign w_slot       = !r_ovalid || !i_out_stall;
    assign w_last_entry = (r_e + CW'(1)) == i_limit;
    assign w_sk         = SW'(r_k);
    assign w_in_code    = (w_sk >= SW'(r_start)) && (w_sk < SW'(r_start) + SW'(r_clen));
    assign w_coff       = w_sk - SW'(r_start);
    assign w_htotal     = SW'(r_wlen) - SW'(r_plen) + SW'(r_clen);

    always_comb begin
        if (r_state == S_CMP_CHK) begin
            w_widx_s = SW'(r_off) + SW'(r_j);
        end else if (w_sk < SW'(r_start)) begin
            w_widx_s = w_sk;
        end else begin
            w_widx_s = w_sk + SW'(r_plen) - SW'(r_clen);
        end
    end
    assign w_widx  = w_widx_s[IW-1:0];
    assign w_wbyte = r_word[w_widx];

    // next state and datapath
    always_comb begin
        n_state  = r_state;
        n_wlen   = r_wlen;
        n_wovf   = r_wovf;
        n_e      = r_e;
        n_plen   = r_plen;
        n_clen   = r_clen;
        n_j      = r_j;
        n_off    = r_off;
        n_start  = r_start;
        n_k      = r_k;
        n_total  = r_total;
        n_sep    = r_sep;
        n_ovalid = r_ovalid && i_out_stall;
        n_oitem  = r_oitem;
        unique case (r_state)
            S_IDLE: begin
                if (w_pop) begin
                    if (i_job.kind == K_TEXT) begin
                        if (r_wlen < LW'(WORD_MAX)) begin
                            n_wlen = r_wlen + LW'(1);
                        end else begin
                            n_wovf = 1'b1;
                        end
                    end else if (i_job.kind == K_SEP) begin
                        n_sep = i_job.item.char_in;
                        n_e   = '0;
                        if (i_limit == '0) begin
                            n_start = r_wlen;
                            n_plen  = '0;
                            n_clen  = '0;
                            n_total = TW'(r_wlen);
                            n_k     = '0;
                            n_state = (r_wlen == '0) ? S_SEP : S_EMIT_ISSUE;
                        end else begin
                            n_state = S_LEN_ISSUE;
                        end
                    end
                end
            end
            S_LEN_ISSUE: n_state = S_LEN_CHK;
            S_LEN_CHK: begin
                n_plen = w_len_rdata[9:5];
                n_clen = w_len_rdata[4:0];
                n_off  = '0;
                n_j    = '0;
                if (w_len_rdata[9:5] == 5'd0 || SW'(w_len_rdata[9:5]) > SW'(r_wlen)) begin
                    if (w_last_entry) begin
                        n_start = r_wlen;
                        n_plen  = '0;
                        n_clen  = '0;
                        n_total = TW'(r_wlen);
                        n_k     = '0;
                        n_state = (r_wlen == '0) ? S_SEP : S_EMIT_ISSUE;
                    end else begin
                        n_e     = r_e + CW'(1);
                        n_state = S_LEN_ISSUE;
                    end
                end else begin
                    n_state = S_CMP_ISSUE;
                end
            end
            S_CMP_ISSUE: n_state = S_CMP_CHK;
            S_CMP_CHK: begin
                if (w_wbyte == w_pat_rdata) begin
                    if (r_j + 5'd1 == r_plen) begin
                        n_start = r_off;
                        n_total = TW'(w_htotal);
                        n_k     = '0;
                        n_state = (w_htotal == '0) ? S_SEP : S_EMIT_ISSUE;
                    end else begin
                        n_j     = r_j + 5'd1;
                        n_state = S_CMP_ISSUE;
                    end
                end else begin
                    n_j   = '0;
                    n_off = r_off + LW'(1);
                    if (SW'(r_off) + SW'(1) + SW'(r_plen) > SW'(r_wlen)) begin
                        if (w_last_entry) begin
                            n_start = r_wlen;
                            n_plen  = '0;
                            n_clen  = '0;
                            n_total = TW'(r_wlen);
                            n_k     = '0;
                            n_state = S_EMIT_ISSUE;
                        end else begin
                            n_e     = r_e + CW'(1);
                            n_state = S_LEN_ISSUE;
                        end
                    end else begin
                        n_state = S_CMP_ISSUE;
                    end
                end
            end
            S_EMIT_ISSUE: n_state = S_EMIT_PUT;
            S_EMIT_PUT: begin
                if (w_slot) begin
                    n_ovalid         = 1'b1;
                    n_oitem.char_out = w_in_code ? w_code_rdata : w_wbyte;
                    n_oitem.last     = 1'b0;
                    n_oitem.overflow = r_wovf;
                    n_k              = r_k + TW'(1);
                    n_state          = (r_k + TW'(1) == r_total) ? S_SEP : S_EMIT_ISSUE;
                end
            end
            S_SEP: begin
                if (w_slot) begin
                    n_ovalid         = 1'b1;
                    n_oitem.char_out = r_sep;
                    n_oitem.last     = 1'b1;
                    n_oitem.overflow = r_wovf;
                    n_wlen           = '0;
                    n_wovf           = 1'b0;
                    n_state          = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // memory controls and handshake outputs
    always_comb begin
        w_pat_we     = w_pop && (i_job.kind == K_PAT);
        w_code_we    = w_pop && (i_job.kind == K_CODE);
        w_len_we     = w_pop && (i_job.kind == K_LEN);
        w_pat_waddr  = PAW'(i_job.item.entry) * PAW'(PATTERN_MAX) + PAW'(i_job.item.position);
        w_code_waddr = CAW'(i_job.item.entry) * CAW'(CODE_MAX) + CAW'(i_job.item.position);
        w_len_waddr  = EW'(i_job.item.entry);
        w_len_raddr  = r_e[EW-1:0];
        w_pat_raddr  = PAW'(r_e[EW-1:0]) * PAW'(PATTERN_MAX) + PAW'(r_j);
        w_code_raddr = CAW'(r_e[EW-1:0]) * CAW'(CODE_MAX) + CAW'(w_coff[4:0]);
        o_hs_pop.pop   = w_pop;
        o_hs_pop.valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wlen   <= '0;
            r_wovf   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wlen   <= n_wlen;
            r_wovf   <= n_wovf;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_e     <= n_e;
        r_plen  <= n_plen;
        r_clen  <= n_clen;
        r_j     <= n_j;
        r_off   <= n_off;
        r_start <= n_start;
        r_k     <= n_k;
        r_total <= n_total;
        r_sep   <= n_sep;
        r_oitem <= n_oitem;
        if (w_pop && i_job.kind == K_TEXT && r_wlen < LW'(WORD_MAX)) begin
            r_word[r_wlen[IW-1:0]] <= i_job.item.char_in;
        end
    end

    assign o_out_valid = r_ovalid;
    assign o_item      = r_oitem;

`ifndef SYNTH
    a_wlen_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wlen <= LW'(WORD_MAX))
        else $error("word length beyond buffer");
    a_cmp_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_CMP_CHK |-> SW'(r_off) + SW'(r_plen) <= SW'(r_wlen))
        else $error("compare window past word end");
    a_emit_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT_ISSUE || r_state == S_EMIT_PUT) |-> r_k < r_total)
        else $error("emit cursor past total");
    a_sep_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEP && w_slot) |=> (r_wlen == '0 && !r_wovf && o_item.last))
        else $error("separator did not close word");
`endif
endmodule
`default_nettype wire

>>> rtl/core/dictionary_word_substituter.sv
// Top level of the dictionary word substituter: config register, front and back.
// Uses dws_pkg, dws_front, dws_back.
//
// Load words (pattern byte, code byte, entry lengths) and text bytes enter on
// the input channel and wait in a two-word queue; loads and plain text bytes
// are handled from the idle state. A space or newline closes the word: entries
// are tried in order, each with a length read (length issue and check states),
// then a byte-serial compare against the pattern RAM at each word offset
// (compare issue and check states); the first matching entry and offset win.
// The rewritten word then leaves one byte at a time (emit issue and put
// states), held while the output stalls, followed by the separator with last set.
// Dictionary RAMs come up undefined; entries must be loaded before use.
`default_nettype none
module dictionary_word_substituter #(
    parameter int DICT_ENTRIES = 256,
    parameter int WORD_MAX     = 32,
    parameter int PATTERN_MAX  = 16,
    parameter int CODE_MAX     = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire dws_pkg::t_in_item  i_item,
    output logic                    o_in_stall,
    output logic                    o_out_valid,
    output dws_pkg::t_out_item      o_item,
    input  wire logic               i_out_stall,
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [8:0]         i_cfg_data
);
    import dws_pkg::*;

    localparam int CW = $clog2(DICT_ENTRIES + 1);

    logic [8:0]    r_cfg, n_cfg;
    logic [CW-1:0] w_limit;
    t_job          w_job;
    t_job_hs       w_hs_valid, w_hs_pop;

    assign o_cfg_ready = 1'b1;
    assign n_cfg       = (i_cfg_valid && o_cfg_ready) ? i_cfg_data : r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign w_limit = (11'(r_cfg) > 11'(DICT_ENTRIES)) ? CW'(DICT_ENTRIES) : CW'(r_cfg);

    dws_front #(
        .DICT_ENTRIES(DICT_ENTRIES), .PATTERN_MAX(PATTERN_MAX), .CODE_MAX(CODE_MAX)
    ) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid), .i_item(i_item),
        .o_in_stall(o_in_stall), .o_job(w_job), .o_hs_valid(w_hs_valid),
        .i_hs_pop(w_hs_pop)
    );

    dws_back #(
        .DICT_ENTRIES(DICT_ENTRIES), .WORD_MAX(WORD_MAX), .PATTERN_MAX(PATTERN_MAX),
        .CODE_MAX(CODE_MAX), .CW(CW)
    ) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_limit(w_limit), .i_job(w_job),
        .i_hs_valid(w_hs_valid), .o_hs_pop(w_hs_pop), .o_out_valid(o_out_valid),
        .o_item(o_item), .i_out_stall(i_out_stall)
    );
endmodule
`default_nettype wire

>>> sim/dws_checker.sv
// Checker for the dictionary word substituter: watches the load/text, config and output
// channels, predicts the rewritten words and compares them byte by byte.
// Depends on dws_pkg.
`default_nettype none
module dws_checker (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire dws_pkg::t_in_item  i_in_item,
    input  wire logic               i_in_stall,
    input  wire logic               i_out_valid,
    input  wire dws_pkg::t_out_item i_out_item,
    input  wire logic               i_out_stall,
    input  wire logic               i_cfg_valid,
    input  wire logic               i_cfg_ready,
    input  wire logic [8:0]         i_cfg_data,
    output int                      o_fail_count,
    output int                      o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import dws_pkg::*;

    localparam int DICT_SIZE  = 256;
    localparam int WORD_LIMIT = 32;
    localparam int PAT_LIMIT  = 16;
    localparam int CODE_LIMIT = 16;

    logic [7:0] pat_bytes [DICT_SIZE][PAT_LIMIT];
    logic [7:0] code_bytes [DICT_SIZE][CODE_LIMIT];
    int         pat_len [DICT_SIZE];
    int         code_len [DICT_SIZE];
    logic [7:0] word_buf [WORD_LIMIT];
    int         word_len;
    logic       word_ovf;
    int         n_entries;
    t_out_item  expected_bytes[$];
    int         mismatches;

    assign o_fail_count = mismatches;

    function automatic void put_byte(input logic [7:0] c, input logic is_last);
        expected_bytes.push_back(t_out_item'{char_out: c, last: is_last, overflow: word_ovf});
    endfunction

    task automatic rewrite_word(input logic [7:0] sep);
        int  limit;
        int  hit;
        int  hit_e;
        int  pl;
        bit  same;
        limit = n_entries > DICT_SIZE ? DICT_SIZE : n_entries;
        hit   = -1;
        hit_e = 0;
        for (int e = 0; e < limit && hit < 0; e++) begin
            pl = pat_len[e];
            if (pl != 0 && pl <= word_len) begin
                for (int off = 0; off + pl <= word_len && hit < 0; off++) begin
                    same = 1'b1;
                    for (int j = 0; j < pl; j++)
                        if (word_buf[off + j] != pat_bytes[e][j]) same = 1'b0;
                    if (same) begin
                        hit   = off;
                        hit_e = e;
                    end
                end
            end
        end
        if (hit < 0) begin
            for (int i = 0; i < word_len; i++) put_byte(word_buf[i], 1'b0);
        end else begin
            for (int i = 0; i < hit; i++) put_byte(word_buf[i], 1'b0);
            for (int i = 0; i < code_len[hit_e]; i++) put_byte(code_bytes[hit_e][i], 1'b0);
            for (int i = hit + pat_len[hit_e]; i < word_len; i++) put_byte(word_buf[i], 1'b0);
        end
        put_byte(sep, 1'b1);
        word_len = 0;
        word_ovf = 1'b0;
    endtask

    task automatic take_word(input t_in_item it);
        case (t_cmd'(it.command))
            CMD_PAT:  pat_bytes[it.entry][it.position] = it.char_in;
            CMD_CODE: code_bytes[it.entry][it.position] = it.char_in;
            CMD_LEN: begin
                pat_len[it.entry]  = it.pattern_length > PAT_LIMIT ? PAT_LIMIT : it.pattern_length;
                code_len[it.entry] = it.code_length > CODE_LIMIT ? CODE_LIMIT : it.code_length;
            end
            default: begin
                if (it.char_in == SEP_SPACE || it.char_in == SEP_NEWLINE) begin
                    rewrite_word(it.char_in);
                end else if (word_len < WORD_LIMIT) begin
                    word_buf[word_len] = it.char_in;
                    word_len++;
                end else begin
                    word_ovf = 1'b1;
                end
            end
        endcase
    endtask

    initial mismatches = 0;

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            n_entries = 0;
            word_len  = 0;
            word_ovf  = 1'b0;
            expected_bytes.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) n_entries = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected output word: char %0d last %0b ovf %0b",
                                 i_out_item.char_out, i_out_item.last, i_out_item.overflow);
                end else begin
                    want = expected_bytes.pop_front();
                    if (want !== i_out_item) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected char %0d last %0b ovf %0b, got %0d %0b %0b",
                                     want.char_out, want.last, want.overflow,
                                     i_out_item.char_out, i_out_item.last, i_out_item.overflow);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) take_word(i_in_item);
        end
        o_pending <= expected_bytes.size();
    end
endmodule
`default_nettype wire

>>> sim/tb_dictionary_word_substituter.sv
// Testbench top for the dictionary word substituter: clock, reset, dictionary loads,
// text stimulus, config phases and the verdict. Depends on dws_pkg, dws_checker and the top level.
`default_nettype none
module tb_dictionary_word_substituter;
    timeunit 1ns;
    timeprecision 1ps;
    import dws_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    t_in_item   in_item = '0;
    logic       out_stall = 1'b0;
    logic       cfg_valid = 1'b0;
    logic [8:0] cfg_data = '0;
    logic       o_in_stall, o_out_valid, o_cfg_ready;
    t_out_item  o_item;
    int         fail_count, pending;
    logic       quiet = 1'b0;
    logic       hold_go = 1'b0;

    dictionary_word_substituter u_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_item(in_item), .o_in_stall(o_in_stall),
        .o_out_valid(o_out_valid), .o_item(o_item), .i_out_stall(out_stall),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(o_cfg_ready), .i_cfg_data(cfg_data)
    );

    dws_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .i_in_item(in_item), .i_in_stall(o_in_stall),
        .i_out_valid(o_out_valid), .i_out_item(o_item), .i_out_stall(out_stall),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(o_cfg_ready), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial forever #4 clk = ~clk;

    initial begin
        for (int n = 0; n < CYCLE_LIMIT; n++) @(posedge clk);
        $display("tb_dictionary_word_substituter NOT OK");
        $finish;
    end

    // receiver: random stalls, one long hold-off on request
    initial begin
        bit held;
        held = 1'b0;
        forever begin
            @(posedge clk);
            if (hold_go && !held) begin
                held = 1'b1;
                out_stall <= 1'b1;
                repeat (400) @(posedge clk);
            end
            out_stall <= !quiet && ($urandom_range(99) < 6);
        end
    end

    function automatic t_in_item mk(input t_cmd c, input int e, input int p, input int ch,
                                    input int pl, input int cl);
        return t_in_item'{command: c, entry: e[7:0], position: p[3:0], char_in: ch[7:0],
                          pattern_length: pl[4:0], code_length: cl[4:0]};
    endfunction

    task automatic send(input t_in_item it);
        if (!quiet && $urandom_range(99) < 6) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_item  <= it;
        in_valid <= 1'b1;
        do @(posedge clk); while (o_in_stall);
    endtask

    task automatic txt(input int ch);
        send(mk(CMD_TEXT, $urandom_range(255), $urandom_range(15), ch,
                $urandom_range(31), $urandom_range(31)));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        repeat (2) @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_cfg(input int value);
        cfg_data  <= value[8:0];
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!o_cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic rand_word(input int maxlen);
        int n;
        int ch;
        n = $urandom_range(0, maxlen);
        for (int i = 0; i < n; i++) begin
            if ($urandom_range(9) != 0) begin
                ch = "a" + $urandom_range(3);
            end else begin
                do ch = $urandom_range(255); while (ch == SEP_SPACE || ch == SEP_NEWLINE);
            end
            txt(ch);
        end
        txt($urandom_range(4) != 0 ? SEP_SPACE : SEP_NEWLINE);
    endtask

    initial begin
        int cfgs[4];
        int pl;
        int cl;
        int words;
        cfgs = '{1, 3, 8, 0};
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no entries searched: words pass through
        txt("a"); txt("b"); txt(SEP_SPACE);
        txt(SEP_NEWLINE);
        settle();

        // entry 0 "ab" -> "Z", entry 1 never matches, entry 2 saturated, entry 3 "c" -> nothing
        send(mk(CMD_PAT, 0, 0, "a", 0, 0));
        send(mk(CMD_PAT, 0, 1, "b", 0, 0));
        send(mk(CMD_CODE, 0, 0, "Z", 0, 0));
        send(mk(CMD_LEN, 0, 0, 0, 2, 1));
        send(mk(CMD_LEN, 1, 0, 0, 0, 16));
        for (int p = 0; p < 16; p++) send(mk(CMD_PAT, 2, p, "e", 0, 0));
        send(mk(CMD_LEN, 2, 0, 0, 31, 31));
        send(mk(CMD_PAT, 3, 15, "c", 0, 0));
        send(mk(CMD_PAT, 3, 0, "c", 0, 0));
        send(mk(CMD_LEN, 3, 0, 0, 1, 0));

        // entries 4 to 7: short random patterns, every byte in use written
        for (int e = 4; e < 8; e++) begin
            pl = $urandom_range(1, 3);
            cl = $urandom_range(0, 3);
            for (int p = 0; p < pl; p++) send(mk(CMD_PAT, e, p, "a" + $urandom_range(3), 0, 0));
            for (int p = 0; p < cl; p++) send(mk(CMD_CODE, e, p, $urandom_range(255), 0, 0));
            send(mk(CMD_LEN, e, 0, 0, pl, cl));
        end
        settle();
        write_cfg(4);
        txt("x"); txt("a"); txt("b"); txt("y"); txt(SEP_SPACE);
        txt("d"); txt("c"); txt(SEP_NEWLINE);
        txt(SEP_SPACE);
        txt(8'hFF); txt(8'h00); txt(SEP_SPACE);
        for (int i = 0; i < 36; i++) txt("d");
        txt(SEP_NEWLINE);
        settle();

        for (int ph = 0; ph < 4; ph++) begin
            write_cfg(cfgs[ph]);
            quiet   <= (ph == 1);
            hold_go <= (ph == 0);
            words = 4;
            for (int w = 0; w < words; w++) begin
                if ($urandom_range(9) == 0)
                    send(mk(t_cmd'($urandom_range(1)), $urandom_range(255), $urandom_range(15),
                            "a" + $urandom_range(3), $urandom_range(31), $urandom_range(31)));
                if ($urandom_range(19) == 0)
                    txt($urandom_range(255));
                rand_word(5);
            end
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("tb_dictionary_word_substituter OK");
        end else begin
            $display("tb_dictionary_word_substituter NOT OK");
        end
        $finish;
    end
endmodule
`default_nettype wire

>>> dictionary_word_substituter.f
rtl/core/dws_pkg.sv
rtl/core/dws_ram.sv
rtl/core/dws_front.sv
rtl/core/dws_back.sv
rtl/core/dictionary_word_substituter.sv
sim/dws_checker.sv
sim/tb_dictionary_word_substituter.sv
